### rtl/rar_pkg.sv
// Package for the rational arithmetic reduce block.
// Holds operation and status codes and default widths; no dependencies.
package rar_pkg;
	localparam int DataWidthDef = 32;
	localparam int MagW = 64;

	localparam logic [1:0] OP_ADD = 2'd0;
	localparam logic [1:0] OP_SUB = 2'd1;
	localparam logic [1:0] OP_MUL = 2'd2;
	localparam logic [1:0] OP_DIV = 2'd3;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_ZDEN = 2'd1;
	localparam logic [1:0] ST_OVF  = 2'd2;

	typedef logic [MagW-1:0] mag_t;

	// Request to the shared divider: start, dividend, divisor.
	typedef struct packed {
		logic start;
		mag_t dividend;
		mag_t divisor;
	} div_req_t;

	typedef struct packed {
		logic done;
		mag_t quot;
		mag_t rem;
	} div_rsp_t;
endpackage

### rtl/rational_arith_reduce_top.sv
// Top level of the rational arithmetic reduce block: sequencer and datapath.
// Depends on rar_pkg and rar_div.
//
// Usage: an item (op, a_num, a_den, b_num, b_den) enters on the in_valid /
// in_ready channel; one result (res_num, res_den, status) leaves on the
// out_valid / out_ready channel for every item. Operands are taken as their
// low DATA_WIDTH bits in two's complement. The block handles one item at a
// time: in_ready is high only while it is idle and no result is pending.
// Cross products come from one shared magnitude multiplier, one per cycle
// (up to three products plus an add or subtract). Reduction runs Euclid's
// algorithm on the shared 64-bit restoring divider; each remainder needs a
// start, 64 quotient steps and a final look at the result. The gcd needs
// up to about 93 remainders for 64-bit values, and two exact divisions
// follow. When the numerator or denominator is zero, the reduction is
// skipped and the result goes straight to the output. Reset empties the
// block: no result is pending and in_ready rises. When the receiver
// stalls, the result is held in its output register and no new item is
// taken until it has been delivered.
module rational_arith_reduce_top #(
	parameter int DATA_WIDTH = rar_pkg::DataWidthDef
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         op,
	input  logic signed [31:0] a_num,
	input  logic signed [31:0] a_den,
	input  logic signed [31:0] b_num,
	input  logic signed [31:0] b_den,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] res_num,
	output logic [30:0]        res_den,
	output logic [1:0]         status
);
	import rar_pkg::*;

	localparam int OW = DATA_WIDTH + 1;

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_M0    = 4'd1;
	localparam logic [3:0] S_M1    = 4'd2;
	localparam logic [3:0] S_M2    = 4'd3;
	localparam logic [3:0] S_CHK   = 4'd4;
	localparam logic [3:0] S_GCD   = 4'd5;
	localparam logic [3:0] S_GWAIT = 4'd6;
	localparam logic [3:0] S_DN    = 4'd7;
	localparam logic [3:0] S_DNW   = 4'd8;
	localparam logic [3:0] S_DD    = 4'd9;
	localparam logic [3:0] S_DDW   = 4'd10;
	localparam logic [3:0] S_FIN   = 4'd11;
	localparam logic [3:0] S_OUT   = 4'd12;

	logic [3:0]  state_q;
	logic [1:0]  op_q;
	logic [OW-1:0] an_q, ad_q, bn_q, bd_q;
	logic        ann_q, adn_q, bnn_q, bdn_q;
	mag_t        p_q;
	logic        pn_q;
	mag_t        num_q, den_q;
	logic        numn_q, denn_q;
	mag_t        gx_q, gy_q;
	mag_t        nm_q;
	logic signed [31:0] rnum_q;
	logic [30:0] rden_q;
	logic [1:0]  st_q;

	logic [OW-1:0] mul_a, mul_b;
	logic          mul_na, mul_nb;
	mag_t          prod;
	logic          prod_n;
	div_req_t      dreq;
	div_rsp_t      drsp;

	// Magnitude of the low DATA_WIDTH bits taken as two's complement.
	function automatic logic [OW-1:0] mag_of(input logic [31:0] v);
		logic [DATA_WIDTH-1:0] w;
		w = v[DATA_WIDTH-1:0];
		if (w[DATA_WIDTH-1])
			return {1'b0, ~w} + OW'(1);
		return {1'b0, w};
	endfunction

	function automatic logic neg_of(input logic [31:0] v);
		return v[DATA_WIDTH-1];
	endfunction

	// Shared multiplier operand selection.
	always_comb begin
		mul_a = ad_q; mul_na = adn_q;
		mul_b = bd_q; mul_nb = bdn_q;
		unique case (state_q)
			S_M0: begin
				mul_a = an_q; mul_na = ann_q;
				if (op_q == OP_MUL) begin
					mul_b = bn_q; mul_nb = bnn_q;
				end else begin
					mul_b = bd_q; mul_nb = bdn_q;
				end
			end
			S_M1: begin
				if (op_q == OP_DIV) begin
					mul_a = ad_q; mul_na = adn_q;
					mul_b = bn_q; mul_nb = bnn_q;
				end else if (op_q == OP_MUL) begin
					mul_a = ad_q; mul_na = adn_q;
					mul_b = bd_q; mul_nb = bdn_q;
				end else begin
					mul_a = bn_q; mul_na = bnn_q;
					mul_b = ad_q; mul_nb = adn_q;
				end
			end
			default: begin
				mul_a = ad_q; mul_na = adn_q;
				mul_b = bd_q; mul_nb = bdn_q;
			end
		endcase
	end

	assign prod   = MagW'(mul_a) * MagW'(mul_b);
	assign prod_n = (mul_na != mul_nb) && (prod != '0);

	// Signed-magnitude add or subtract of the first product and the second.
	logic  y_n;
	mag_t  sum_m;
	logic  sum_n;
	always_comb begin
		y_n = (op_q == OP_SUB) ? !prod_n : prod_n;
		if (prod == '0)
			y_n = 1'b0;
		if (pn_q == y_n) begin
			sum_m = p_q + prod;
			sum_n = pn_q;
		end else if (p_q >= prod) begin
			sum_m = p_q - prod;
			sum_n = pn_q;
		end else begin
			sum_m = prod - p_q;
			sum_n = y_n;
		end
		if (sum_m == '0)
			sum_n = 1'b0;
	end

	always_comb begin
		dreq.start    = 1'b0;
		dreq.dividend = gx_q;
		dreq.divisor  = gy_q;
		unique case (state_q)
			S_GCD: dreq.start = 1'b1;
			S_DN: begin
				dreq.start    = 1'b1;
				dreq.dividend = num_q;
				dreq.divisor  = gx_q;
			end
			S_DD: begin
				dreq.start    = 1'b1;
				dreq.dividend = den_q;
				dreq.divisor  = gx_q;
			end
			default: dreq.start = 1'b0;
		endcase
	end

	rar_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (dreq),
		.rsp    (drsp)
	);

	// Range check on the reduced values.
	mag_t lim;
	logic fin_n;
	assign lim   = (MagW'(1) << (DATA_WIDTH - 1)) - MagW'(1);
	assign fin_n = (numn_q != denn_q) && (nm_q != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE:  if (in_valid) state_q <= S_M0;
				S_M0:    state_q <= S_M1;
				S_M1:    state_q <= (op_q == OP_ADD || op_q == OP_SUB) ? S_M2 : S_CHK;
				S_M2:    state_q <= S_CHK;
				S_CHK: begin
					if (den_q == '0 || num_q == '0) state_q <= S_OUT;
					else state_q <= S_GCD;
				end
				S_GCD:   state_q <= S_GWAIT;
				S_GWAIT: begin
					if (drsp.done) begin
						if (drsp.rem == '0) state_q <= S_DN;
						else state_q <= S_GCD;
					end
				end
				S_DN:    state_q <= S_DNW;
				S_DNW:   if (drsp.done) state_q <= S_DD;
				S_DD:    state_q <= S_DDW;
				S_DDW:   if (drsp.done) state_q <= S_FIN;
				S_FIN:   state_q <= S_OUT;
				S_OUT:   if (out_ready) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				op_q  <= op;
				an_q  <= mag_of(a_num); ann_q <= neg_of(a_num);
				ad_q  <= mag_of(a_den); adn_q <= neg_of(a_den);
				bn_q  <= mag_of(b_num); bnn_q <= neg_of(b_num);
				bd_q  <= mag_of(b_den); bdn_q <= neg_of(b_den);
			end
			S_M0: begin
				p_q  <= prod;
				pn_q <= prod_n;
			end
			S_M1: begin
				if (op_q == OP_ADD || op_q == OP_SUB) begin
					num_q  <= sum_m;
					numn_q <= sum_n;
				end else if (op_q == OP_DIV) begin
					num_q  <= p_q;
					numn_q <= pn_q;
					den_q  <= prod;
					denn_q <= prod_n;
				end else begin
					num_q  <= p_q;
					numn_q <= pn_q;
					den_q  <= prod;
					denn_q <= prod_n;
				end
			end
			S_M2: begin
				den_q  <= prod;
				denn_q <= prod_n;
			end
			S_CHK: begin
				gx_q <= num_q;
				gy_q <= den_q;
				if (den_q == '0) begin
					rnum_q <= '0; rden_q <= '0; st_q <= ST_ZDEN;
				end else begin
					rnum_q <= '0; rden_q <= 31'd1; st_q <= ST_OK;
				end
			end
			S_GWAIT: begin
				if (drsp.done) begin
					if (drsp.rem == '0) begin
						gx_q <= gy_q;
					end else begin
						gx_q <= gy_q;
						gy_q <= drsp.rem;
					end
				end
			end
			S_DNW: if (drsp.done) nm_q <= drsp.quot;
			S_DDW: if (drsp.done) gy_q <= drsp.quot;
			S_FIN: begin
				if (gy_q > lim || nm_q > lim + (fin_n ? MagW'(1) : MagW'(0))) begin
					rnum_q <= '0; rden_q <= '0; st_q <= ST_OVF;
				end else begin
					rnum_q <= fin_n ? 32'(MagW'(0) - nm_q) : nm_q[31:0];
					rden_q <= gy_q[30:0];
					st_q   <= ST_OK;
				end
			end
			default: begin
			end
		endcase
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = (state_q == S_OUT);
	assign res_num   = rnum_q;
	assign res_den   = rden_q;
	assign status    = st_q;

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid)) else $error("accept while result pending");
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status == ST_OK || status == ST_ZDEN || status == ST_OVF))
		else $error("bad status");
	a_zden_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != ST_OK) |-> (res_num == '0 && res_den == '0))
		else $error("flagged result not cleared");
	a_ok_den: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == ST_OK) |-> (res_den != '0))
		else $error("zero denominator reported ok");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(res_num)))
		else $error("result dropped under stall");
endmodule

### rtl/rar_div.sv
// Shared restoring divider, one quotient bit per cycle, 64-bit operands.
// Depends on rar_pkg.
module rar_div (
	input  logic              clk,
	input  logic              arst_n,
	input  rar_pkg::div_req_t req,
	output rar_pkg::div_rsp_t rsp
);
	import rar_pkg::*;

	logic         busy_q;
	logic [6:0]   cnt_q;
	mag_t         quot_q;
	mag_t         rem_q;
	mag_t         dvs_q;
	logic         done_q;
	logic [MagW:0] trial;
	logic [MagW:0] diff;

	assign trial = {rem_q, quot_q[MagW-1]};
	assign diff  = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 7'(MagW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quot_q <= req.dividend;
			rem_q  <= '0;
			dvs_q  <= req.divisor;
		end else if (busy_q) begin
			if (!diff[MagW]) begin
				rem_q  <= diff[MagW-1:0];
				quot_q <= {quot_q[MagW-2:0], 1'b1};
			end else begin
				rem_q  <= trial[MagW-1:0];
				quot_q <= {quot_q[MagW-2:0], 1'b0};
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = quot_q;
	assign rsp.rem  = rem_q;
endmodule

### tb/rational_arith_reduce_checker.sv
`timescale 1ns / 1ps
// Checker for the rational arithmetic reduce block: watches both channels,
// predicts each reduced fraction and compares it with what leaves. Uses rar_pkg.
module rational_arith_reduce_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic [1:0]         op,
	input  logic signed [31:0] a_num,
	input  logic signed [31:0] a_den,
	input  logic signed [31:0] b_num,
	input  logic signed [31:0] b_den,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic signed [31:0] res_num,
	input  logic [30:0]        res_den,
	input  logic [1:0]         status,
	output int                 fail_count,
	output int                 pending
);
	import rar_pkg::*;

	typedef struct {
		logic [31:0] num;
		logic [30:0] den;
		logic [1:0]  st;
	} fraction_t;

	fraction_t expected_fracs[$];

	assign pending = expected_fracs.size();

	// Signed products of 32-bit operands, each exact in 66 bits.
	function automatic fraction_t reduce_fraction(logic [1:0] opc, logic signed [31:0] an,
			logic signed [31:0] ad, logic signed [31:0] bn, logic signed [31:0] bd);
		logic signed [65:0] n, d, lim;
		logic [65:0] nm, dm, x, y, t;
		fraction_t r;
		logic neg;
		r.num = '0;
		r.den = '0;
		r.st = ST_OK;
		case (opc)
			OP_ADD: begin
				n = an * bd + bn * ad;
				d = ad * bd;
			end
			OP_SUB: begin
				n = an * bd - bn * ad;
				d = ad * bd;
			end
			OP_MUL: begin
				n = an * bn;
				d = ad * bd;
			end
			default: begin
				n = an * bd;
				d = ad * bn;
			end
		endcase
		if (d == 0) begin
			r.st = ST_ZDEN;
			return r;
		end
		nm = (n < 0) ? -n : n;
		dm = (d < 0) ? -d : d;
		x = nm;
		y = dm;
		while (y != 0) begin
			t = x % y;
			x = y;
			y = t;
		end
		nm = nm / x;
		dm = dm / x;
		neg = ((n < 0) != (d < 0)) && nm != 0;
		lim = 66'sh7FFFFFFF;
		if (dm > lim || nm > lim + (neg ? 1 : 0)) begin
			r.st = ST_OVF;
			return r;
		end
		r.num = neg ? -nm[31:0] : nm[31:0];
		r.den = dm[30:0];
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		fraction_t e;
		int errs;
		errs = 0;
		if (!arst_n) begin
			fail_count <= 0;
			expected_fracs.delete();
		end else begin
			if (in_valid && in_ready)
				expected_fracs.push_back(reduce_fraction(op, a_num, a_den, b_num, b_den));
			if (out_valid && out_ready) begin
				if (expected_fracs.size() == 0) begin
					$error("result with nothing expected: num %0d den %0d status %0d",
						res_num, res_den, status);
					errs++;
				end else begin
					e = expected_fracs.pop_front();
					if (res_num !== e.num) begin
						$error("res_num expected %0d actual %0d", $signed(e.num), res_num);
						errs++;
					end
					if (res_den !== e.den) begin
						$error("res_den expected %0d actual %0d", e.den, res_den);
						errs++;
					end
					if (status !== e.st) begin
						$error("status expected %0d actual %0d", e.st, status);
						errs++;
					end
				end
			end
			if (errs != 0)
				fail_count <= fail_count + errs;
		end
	end
endmodule

### tb/rational_arith_reduce_top_tb.sv
`timescale 1ns / 1ps
// Top of the rational arithmetic reduce testbench: clock, reset, stimulus
// and verdict. Depends on rar_pkg, rational_arith_reduce_top and its checker.
module rational_arith_reduce_top_tb;
	import rar_pkg::*;

	localparam int RandomItems = 1700;
	// Cycles without any handshake before the run is declared hung. One item
	// may take its full Euclid reduction plus the longest receiver stall.
	localparam int HangLimit = 40000;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [1:0]         op = OP_ADD;
	logic signed [31:0] a_num = '0;
	logic signed [31:0] a_den = 32'sd1;
	logic signed [31:0] b_num = '0;
	logic signed [31:0] b_den = 32'sd1;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic signed [31:0] res_num;
	logic [30:0]        res_den;
	logic [1:0]         status;
	int                 fail_count;
	int                 pending;
	int                 idle_cycles = 0;
	int                 rdy_mode = 0;
	bit                 stim_done = 1'b0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	rational_arith_reduce_top dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.op(op), .a_num(a_num), .a_den(a_den), .b_num(b_num), .b_den(b_den),
		.out_valid(out_valid), .out_ready(out_ready),
		.res_num(res_num), .res_den(res_den), .status(status)
	);

	rational_arith_reduce_checker checker_i (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.op(op), .a_num(a_num), .a_den(a_den), .b_num(b_num), .b_den(b_den),
		.out_valid(out_valid), .out_ready(out_ready),
		.res_num(res_num), .res_den(res_den), .status(status),
		.fail_count(fail_count), .pending(pending)
	);

	// The receiver stalls in phases: sometimes always ready, sometimes
	// ready at random with a chance of one in four, sometimes fully random.
	always @(posedge clk) begin
		if (arst_n) begin
			if ($urandom_range(0, 63) == 0)
				rdy_mode <= $urandom_range(0, 2);
			case (rdy_mode)
				0: out_ready <= 1'b1;
				1: out_ready <= ($urandom_range(0, 3) == 0);
				default: out_ready <= 1'($urandom_range(0, 1));
			endcase
		end
	end

	// Watchdog: counts cycles in which neither channel moves an item.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= HangLimit) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// Drives one item and holds it until it is accepted.
	task automatic send_item(logic [1:0] o, logic [31:0] an, logic [31:0] ad,
			logic [31:0] bn, logic [31:0] bd);
		op <= o;
		a_num <= an;
		a_den <= ad;
		b_num <= bn;
		b_den <= bd;
		in_valid <= 1'b1;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	// Drops valid for a random gap, or not at all.
	task automatic sender_gap(int max_gap);
		int gap;
		gap = $urandom_range(0, max_gap);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Operand mix: extremes, small values that make Euclid converge in a few
	// steps and produce exact fits, and full-width random bits.
	function automatic logic [31:0] pick_operand();
		case ($urandom_range(0, 9))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'hFFFF_FFFF;
			3: return 32'd0;
			4: return 32'd1;
			5, 6: return $unsigned($signed($urandom_range(0, 200)) - 100);
			7: return $unsigned($signed($urandom_range(0, 65535)) - 32768);
			default: return $urandom();
		endcase
	endfunction

	initial begin
		logic [31:0] ext[5];
		int burst;
		int sent;
		ext = '{32'h8000_0000, 32'h7FFF_FFFF, 32'd0, 32'd1, 32'hFFFF_FFFF};
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: each operation with simple and extreme operands, zero
		// numerators, zero and 0/0 denominators, integer operands, overflow.
		for (int o = 0; o < 4; o++) begin
			send_item(o[1:0], 32'sd1, 32'sd2, 32'sd1, 32'sd3);
			send_item(o[1:0], 32'sd0, 32'sd5, 32'sd0, 32'sd7);
			send_item(o[1:0], 32'sd3, 32'sd0, 32'sd0, 32'sd0);
			send_item(o[1:0], 32'h8000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'sd1);
			send_item(o[1:0], -32'sd6, 32'sd4, 32'sd9, -32'sd1);
			send_item(o[1:0], 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
		end

		// Pause until every expected result has come.
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);

		// Random part in bursts; most operands come from the extreme list or
		// small ranges, the rest is raw bits.
		sent = 0;
		while (sent < RandomItems) begin
			burst = $urandom_range(1, 20);
			for (int k = 0; k < burst && sent < RandomItems; k++) begin
				if ($urandom_range(0, 7) == 0)
					send_item(2'($urandom_range(0, 3)), ext[$urandom_range(0, 4)],
						ext[$urandom_range(0, 4)], ext[$urandom_range(0, 4)],
						ext[$urandom_range(0, 4)]);
				else
					send_item(2'($urandom_range(0, 3)), pick_operand(), pick_operand(),
						pick_operand(), ($urandom_range(0, 4) == 0) ? 32'd1 : pick_operand());
				sent++;
			end
			sender_gap(($urandom_range(0, 3) == 0) ? 0 : 300);
		end
		in_valid <= 1'b0;

		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (fail_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end
endmodule

### filelist.f
rtl/rar_pkg.sv
rtl/rar_div.sv
rtl/rational_arith_reduce_top.sv
tb/rational_arith_reduce_checker.sv
tb/rational_arith_reduce_top_tb.sv
